// File: hdl/hta_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Handle table allocator package
// Shared codes, sequencer states and the find-free result record.
// ---------------------------------------------------------------------------
package hta_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLOSE  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_PARAM  = 2'd1,
      ST_FULL       = 2'd2,
      ST_BAD_HANDLE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LOOK
   } state_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
   } free_hit_type;

endpackage

// File: hdl/handle_table_allocator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Handle table allocator
// Lowest-free handle table: allocate, lookup and close of object handles.
// ---------------------------------------------------------------------------
// Usage:
//   Drive req_op, req_handle_in and req_object_in and raise start; the
//   transfer happens at the rising edge where start is high and busy is low.
//   Exactly one result per request comes back on rsp_status,
//   rsp_handle_out and rsp_object_out, marked by rsp_strobe for a single
//   cycle. The receiver cannot stall; it must take the result that cycle.
// Flow (WORDS = ceil(ENTRIES/32), 32 with the default table):
//   Allocate walks the used-bit memory one 32-bit word per cycle through the
//   shared find-free unit, from word 0 up to at most WORDS words.
//   Lookup and close make one used-word and object read.
//   Bad opcodes, zero references and malformed handles answer without a read.
//   busy stays high until the result is issued; the next request may be
//   accepted in the strobe cycle.
// Reset:
//   Synchronous, active high. Afterwards a clearing pass zeroes the used-bit
//   memory, all WORDS words, one word per cycle, with busy held high.
//   Object storage is not cleared; its value is returned only for used entries.
// ---------------------------------------------------------------------------
module handle_table_allocator_top #(
   parameter int ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_handle_in,
   input  logic [31:0] req_object_in,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_handle_out,
   output logic [31:0] rsp_object_out
);
   import hta_pkg::*;

   // Geometry of the used-bit memory and the entry index
   localparam int WORDS  = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDX_W  = WORD_W + BIT_W;
   localparam int OBJ_AW = $clog2(ENTRIES);
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS - 1);

   // Sequencer and request registers
   state_type         state_ff, state_in;
   logic [WORD_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              close_ff, close_in;
   logic [31:0]       obj_ff, obj_in;

   // Result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [12:0] rsp_handle_ff, rsp_handle_in;
   logic [31:0] rsp_object_ff, rsp_object_in;

   // Storage ports
   logic              used_we;
   logic [WORD_W-1:0] used_waddr;
   logic [31:0]       used_wdata;
   logic [WORD_W-1:0] used_raddr;
   logic [31:0]       used_rdata;
   logic              obj_we;
   logic [OBJ_AW-1:0] obj_waddr;
   logic [31:0]       obj_wdata;
   logic [OBJ_AW-1:0] obj_raddr;
   logic [31:0]       obj_rdata;

   // Handle decode: slot = handle/4, entry index = slot-1
   logic [29:0]      hdl_slot_m1;
   logic             hdl_ok;
   logic [IDX_W-1:0] hdl_idx;

   // Find-free result for the word on the read port
   free_hit_type     hit;
   logic [IDX_W-1:0] scan_idx;
   logic [IDX_W:0]   scan_slot;
   logic [IDX_W+2:0] scan_handle;
   logic             look_used;

   assign hdl_slot_m1 = req_handle_in[31:2] - 30'd1;
   assign hdl_ok      = (req_handle_in != 32'd0) && (req_handle_in[1:0] == 2'b00)
                        && (hdl_slot_m1 < 30'(ENTRIES));
   assign hdl_idx     = hdl_slot_m1[IDX_W-1:0];

   assign scan_idx    = {ptr_ff, hit.bit_idx};
   assign scan_slot   = {1'b0, scan_idx} + (IDX_W+1)'(1);
   assign scan_handle = {scan_slot, 2'b00};
   assign look_used   = used_rdata[idx_ff[BIT_W-1:0]];

   hta_find_free #(
      .ENTRIES (ENTRIES)
   ) u_find_free (
      .word (used_rdata),
      .last (ptr_ff == LAST_WORD),
      .hit  (hit)
   );

   hta_store #(
      .ENTRIES (ENTRIES),
      .WORDS   (WORDS),
      .WORD_W  (WORD_W),
      .OBJ_AW  (OBJ_AW)
   ) u_store (
      .clock      (clock),
      .used_we    (used_we),
      .used_waddr (used_waddr),
      .used_wdata (used_wdata),
      .used_raddr (used_raddr),
      .used_rdata (used_rdata),
      .obj_we     (obj_we),
      .obj_waddr  (obj_waddr),
      .obj_wdata  (obj_wdata),
      .obj_raddr  (obj_raddr),
      .obj_rdata  (obj_rdata)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      close_ff      <= close_in;
      obj_ff        <= obj_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_object_ff <= rsp_object_in;
   end

   // Sequencer: next state, storage access and result
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      close_in      = close_ff;
      obj_in        = obj_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_object_in = rsp_object_ff;
      used_we       = 1'b0;
      used_waddr    = ptr_ff;
      used_wdata    = '0;
      used_raddr    = ptr_ff;
      obj_we        = 1'b0;
      obj_waddr     = scan_idx[OBJ_AW-1:0];
      obj_wdata     = obj_ff;
      obj_raddr     = idx_ff[OBJ_AW-1:0];

      case (state_ff)
         S_CLEAR: begin
            // zero one used-bit word per cycle
            used_we = 1'b1;
            if (ptr_ff == LAST_WORD) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + WORD_W'(1);
            end
         end

         S_IDLE: begin
            if (start) begin
               rsp_handle_in = '0;
               rsp_object_in = '0;
               case (req_op)
                  OP_ALLOC: begin
                     if (req_object_in == 32'd0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_PARAM;
                     end else begin
                        // start the walk at word 0
                        obj_in     = req_object_in;
                        ptr_in     = '0;
                        used_raddr = '0;
                        state_in   = S_SCAN;
                     end
                  end
                  OP_LOOKUP, OP_CLOSE: begin
                     close_in = (req_op == OP_CLOSE);
                     if (hdl_ok) begin
                        idx_in     = hdl_idx;
                        used_raddr = hdl_idx[IDX_W-1:BIT_W];
                        obj_raddr  = hdl_idx[OBJ_AW-1:0];
                        state_in   = S_LOOK;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_HANDLE;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BAD_PARAM;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (hit.found) begin
               // claim the lowest free entry of this word
               used_we       = 1'b1;
               used_wdata    = used_rdata | (32'd1 << hit.bit_idx);
               obj_we        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_handle_in = 13'(scan_handle);
               state_in      = S_IDLE;
            end else if (ptr_ff == LAST_WORD) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               state_in      = S_IDLE;
            end else begin
               // advance to the next word
               ptr_in     = ptr_ff + WORD_W'(1);
               used_raddr = ptr_ff + WORD_W'(1);
            end
         end

         S_LOOK: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (look_used) begin
               rsp_status_in = ST_OK;
               rsp_object_in = obj_rdata;
               if (close_ff) begin
                  // drop the used bit
                  used_we    = 1'b1;
                  used_waddr = idx_ff[IDX_W-1:BIT_W];
                  used_wdata = used_rdata & ~(32'd1 << idx_ff[BIT_W-1:0]);
               end
            end else begin
               rsp_status_in = ST_BAD_HANDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_object_out = rsp_object_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // A reset starts the clearing pass, so no transfer is taken right after it
   a_reset_busy: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   // A failed result carries no handle and no reference
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK)) |->
         ((rsp_handle_out == 13'd0) && (rsp_object_out == 32'd0)))
      else $error("failed result with nonzero payload");

   // A lookup or close with a tag bit set is answered next cycle as bad handle
   a_tag_bad: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_op == OP_LOOKUP) || (req_op == OP_CLOSE))
         && (req_handle_in[1:0] != 2'b00)) |=>
         (rsp_strobe && (rsp_status == ST_BAD_HANDLE)))
      else $error("malformed handle not rejected");

   // The used-bit memory is never written while idle
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !used_we)
      else $error("used-bit write while idle");

endmodule

// File: hdl/hta_find_free.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Find-free unit
// Lowest clear bit of one used-bit word; bits past the table count as used.
// ---------------------------------------------------------------------------
module hta_find_free #(
   parameter int ENTRIES = 1024
) (
   input  logic [31:0]          word,
   input  logic                 last,
   output hta_pkg::free_hit_type hit
);
   import hta_pkg::*;

   localparam int WORDS     = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int LAST_BITS = ENTRIES - (WORDS - 1) * WORD_BITS;
   localparam logic [31:0] LAST_MASK = 32'((64'd1 << LAST_BITS) - 64'd1);

   logic [31:0] free_bits;
   logic [31:0] low_bit;
   logic [4:0]  enc;

   assign free_bits = ~word & (last ? LAST_MASK : 32'hFFFF_FFFF);
   assign low_bit   = free_bits & (~free_bits + 32'd1);

   // low_bit is one-hot or zero: OR the positions together
   always_comb begin
      enc = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (low_bit[b]) begin
            enc = enc | 5'(b);
         end
      end
   end

   assign hit.found   = |free_bits;
   assign hit.bit_idx = enc;

endmodule

// File: hdl/hta_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Handle table storage
// Used-bit words and object references, one write and one read port each.
// ---------------------------------------------------------------------------
module hta_store #(
   parameter int ENTRIES = 1024,
   parameter int WORDS   = 32,
   parameter int WORD_W  = 5,
   parameter int OBJ_AW  = 10
) (
   input  logic              clock,
   input  logic              used_we,
   input  logic [WORD_W-1:0] used_waddr,
   input  logic [31:0]       used_wdata,
   input  logic [WORD_W-1:0] used_raddr,
   output logic [31:0]       used_rdata,
   input  logic              obj_we,
   input  logic [OBJ_AW-1:0] obj_waddr,
   input  logic [31:0]       obj_wdata,
   input  logic [OBJ_AW-1:0] obj_raddr,
   output logic [31:0]       obj_rdata
);
   import hta_pkg::*;

   logic [31:0] used_mem [0:WORDS-1];
   logic [31:0] obj_mem  [0:ENTRIES-1];
   logic [31:0] used_rdata_ff;
   logic [31:0] obj_rdata_ff;

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_waddr] <= used_wdata;
      end
      used_rdata_ff <= used_mem[used_raddr];
   end

   always_ff @(posedge clock) begin
      if (obj_we) begin
         obj_mem[obj_waddr] <= obj_wdata;
      end
      obj_rdata_ff <= obj_mem[obj_raddr];
   end

   assign used_rdata = used_rdata_ff;
   assign obj_rdata  = obj_rdata_ff;

endmodule
